// ----- hdl/tga_rle_pkg.sv -----
// Shared types and defaults for the TGA run-length image decoder.
package tga_rle_pkg;

  localparam int MaxWidthDefault  = 4096;
  localparam int MaxHeightDefault = 4096;

  typedef enum logic [1:0] {
    KIND_PIXELS  = 2'd0,
    KIND_HDR_OK  = 2'd1,
    KIND_HDR_BAD = 2'd2,
    KIND_TRUNC   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    CMD_HDR_OK  = 2'd0,
    CMD_HDR_BAD = 2'd1,
    CMD_PIXELS  = 2'd2,
    CMD_TRUNC   = 2'd3
  } cmd_op_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_of_file;
    logic       end_of_file;
  } in_t;

  typedef struct packed {
    kind_e        kind;
    logic [1:0]   pixel_count;
    logic [23:0]  address_a;
    logic [31:0]  color_a;
    logic [23:0]  address_b;
    logic [31:0]  color_b;
    logic         image_done;
    logic         last_of_burst;
    logic [12:0]  image_width;
    logic [12:0]  image_height;
  } out_t;

  // One command from the byte parser to the pixel writer.
  typedef struct packed {
    cmd_op_e      op;
    logic         trunc;    // the final result of this command reports truncation
    logic         done;     // the final result of this command holds the last pixel
    logic [7:0]   count;    // pixels in a run, already clipped at the image end
    logic [31:0]  color;
    logic [15:0]  width;
    logic [12:0]  height;
    logic         top;      // rows are stored top-down
    logic [23:0]  base;     // start address of the first row
  } cmd_t;

endpackage

// ----- hdl/tga_rle_fifo.sv -----
// Small first-in first-out queue built from registers.
module tga_rle_fifo #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// ----- hdl/tga_rle_front.sv -----
// Byte parser: header checks, ID skip, packet headers and pixel assembly.
module tga_rle_front
  import tga_rle_pkg::*;
#(
  parameter int MaxWidth  = MaxWidthDefault,
  parameter int MaxHeight = MaxHeightDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic accept_i,
  input  in_t  data_i,
  output logic cmd_push_o,
  output cmd_t cmd_o
);

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_IDSKIP = 2'd1;
  localparam logic [1:0] PH_PIXELS = 2'd2;
  localparam logic [1:0] PH_IDLE   = 2'd3;

  localparam logic [4:0] IdxIdLen    = 5'd0;
  localparam logic [4:0] IdxCmapType = 5'd1;
  localparam logic [4:0] IdxImgType  = 5'd2;
  localparam logic [4:0] IdxWidthLo  = 5'd12;
  localparam logic [4:0] IdxWidthHi  = 5'd13;
  localparam logic [4:0] IdxHeightLo = 5'd14;
  localparam logic [4:0] IdxHeightHi = 5'd15;
  localparam logic [4:0] IdxDepth    = 5'd16;
  localparam logic [4:0] IdxDescr    = 5'd17;

  localparam logic [7:0] TypeRaw    = 8'd2;
  localparam logic [7:0] TypeRle    = 8'd10;
  localparam logic [7:0] Depth24    = 8'd24;
  localparam logic [7:0] Depth32    = 8'd32;
  localparam logic [7:0] AlphaOpaque = 8'd255;

  logic [1:0]  phase_q, phase_d, e_phase;
  logic [4:0]  idx_q, idx_d, e_idx;
  logic [7:0]  skip_q, skip_d, e_skip;
  logic        rle_q, rle_d, e_rle;
  logic        bpp4_q, bpp4_d, e_bpp4;
  logic        top_q, top_d, e_top;
  logic [15:0] width_q, width_d, e_width;
  logic [15:0] height_q, height_d, e_height;
  logic [7:0]  plen_q, plen_d, e_plen;
  logic        prep_q, prep_d, e_prep;
  logic [1:0]  sidx_q, sidx_d, e_sidx;
  logic        bad_q, bad_d, e_bad;
  logic [31:0] remain_q, remain_d;
  logic [31:0] prod_q;
  logic [23:0] base_init_q;
  logic [31:0] base_full;
  logic [7:0]  sample_q [3];
  logic        sample_we;
  logic [7:0]  b;
  logic        hdr_bad, done, cmd_push;
  logic [2:0]  bpp;
  logic [7:0]  cnt, clipped, red, alpha;
  cmd_t        cmd;

  assign b = data_i.data_byte;

  // Pixel total and bottom row start, registered well before the last header byte.
  assign base_full = {16'd0, height_q - 16'd1} * {16'd0, width_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_q      <= '0;
      base_init_q <= '0;
    end else begin
      prod_q      <= {16'd0, width_q} * {16'd0, height_q};
      base_init_q <= base_full[23:0];
    end
  end

  always_comb begin
    // A first byte sees the reset state.
    e_phase  = data_i.first_of_file ? PH_HEADER : phase_q;
    e_idx    = data_i.first_of_file ? 5'd0 : idx_q;
    e_skip   = data_i.first_of_file ? 8'd0 : skip_q;
    e_rle    = data_i.first_of_file ? 1'b0 : rle_q;
    e_bpp4   = data_i.first_of_file ? 1'b0 : bpp4_q;
    e_top    = data_i.first_of_file ? 1'b0 : top_q;
    e_width  = data_i.first_of_file ? 16'd0 : width_q;
    e_height = data_i.first_of_file ? 16'd0 : height_q;
    e_plen   = data_i.first_of_file ? 8'd0 : plen_q;
    e_prep   = data_i.first_of_file ? 1'b0 : prep_q;
    e_sidx   = data_i.first_of_file ? 2'd0 : sidx_q;
    e_bad    = data_i.first_of_file ? 1'b0 : bad_q;

    phase_d  = e_phase;
    idx_d    = e_idx;
    skip_d   = e_skip;
    rle_d    = e_rle;
    bpp4_d   = e_bpp4;
    top_d    = e_top;
    width_d  = e_width;
    height_d = e_height;
    plen_d   = e_plen;
    prep_d   = e_prep;
    sidx_d   = e_sidx;
    bad_d    = e_bad;
    remain_d = remain_q;

    sample_we = 1'b0;
    hdr_bad   = 1'b0;
    done      = 1'b0;
    bpp       = e_bpp4 ? 3'd4 : 3'd3;
    cnt       = 8'd1;
    clipped   = 8'd1;
    red       = e_bpp4 ? sample_q[2] : b;
    alpha     = e_bpp4 ? b : AlphaOpaque;
    cmd_push  = 1'b0;
    cmd       = '0;
    cmd.op    = CMD_TRUNC;

    case (e_phase)
      PH_HEADER: begin
        idx_d = e_idx + 5'd1;
        case (e_idx)
          IdxIdLen:    skip_d = b;
          IdxCmapType: if (b != 8'd0) bad_d = 1'b1;
          IdxImgType: begin
            if (b == TypeRaw) begin
              rle_d = 1'b0;
            end else if (b == TypeRle) begin
              rle_d = 1'b1;
            end else begin
              bad_d = 1'b1;
            end
          end
          IdxWidthLo:  width_d  = {e_width[15:8], b};
          IdxWidthHi:  width_d  = {b, e_width[7:0]};
          IdxHeightLo: height_d = {e_height[15:8], b};
          IdxHeightHi: height_d = {b, e_height[7:0]};
          IdxDepth: begin
            if (b == Depth24) begin
              bpp4_d = 1'b0;
            end else if (b == Depth32) begin
              bpp4_d = 1'b1;
            end else begin
              bad_d = 1'b1;
            end
          end
          IdxDescr:    top_d = b[5];
          default: begin
          end
        endcase
        if (e_idx == IdxDescr) begin
          hdr_bad = bad_d || (e_width == 16'd0) || (e_height == 16'd0) ||
                    (e_width > 16'(MaxWidth)) || (e_height > 16'(MaxHeight));
          cmd_push = 1'b1;
          if (hdr_bad) begin
            cmd.op  = CMD_HDR_BAD;
            phase_d = PH_IDLE;
          end else begin
            cmd.op     = CMD_HDR_OK;
            cmd.width  = e_width;
            cmd.height = e_height[12:0];
            cmd.top    = b[5];
            cmd.base   = b[5] ? 24'd0 : base_init_q;
            remain_d   = prod_q;
            phase_d    = (e_skip != 8'd0) ? PH_IDSKIP : PH_PIXELS;
          end
        end
      end
      PH_IDSKIP: begin
        skip_d = e_skip - 8'd1;
        if (skip_d == 8'd0) begin
          phase_d = PH_PIXELS;
        end
      end
      PH_PIXELS: begin
        if (e_rle && (e_plen == 8'd0)) begin
          prep_d = b[7];
          plen_d = {1'b0, b[6:0]} + 8'd1;
          sidx_d = 2'd0;
        end else if (({1'b0, e_sidx} + 3'd1) < bpp) begin
          sample_we = 1'b1;
          sidx_d    = e_sidx + 2'd1;
        end else begin
          sidx_d = 2'd0;
          if (e_rle) begin
            cnt    = e_prep ? e_plen : 8'd1;
            plen_d = e_prep ? 8'd0 : e_plen - 8'd1;
          end
          // Runs are clipped at the last pixel of the image.
          done      = ({24'd0, cnt} >= remain_q);
          clipped   = done ? remain_q[7:0] : cnt;
          remain_d  = remain_q - {24'd0, clipped};
          cmd_push  = 1'b1;
          cmd.op    = CMD_PIXELS;
          cmd.done  = done;
          cmd.count = clipped;
          cmd.color = {alpha, sample_q[0], sample_q[1], red};
          if (done) begin
            phase_d = PH_IDLE;
          end
        end
      end
      default: begin
      end
    endcase

    // End of file with work still open reports truncation.
    if (data_i.end_of_file && (phase_d != PH_IDLE)) begin
      if (cmd_push) begin
        cmd.trunc = 1'b1;
      end else begin
        cmd_push = 1'b1;
        cmd.op   = CMD_TRUNC;
      end
      phase_d = PH_IDLE;
    end
  end

  assign cmd_push_o = accept_i && cmd_push;
  assign cmd_o      = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HEADER;
      idx_q    <= '0;
      skip_q   <= '0;
      rle_q    <= 1'b0;
      bpp4_q   <= 1'b0;
      top_q    <= 1'b0;
      width_q  <= '0;
      height_q <= '0;
      plen_q   <= '0;
      prep_q   <= 1'b0;
      sidx_q   <= '0;
      bad_q    <= 1'b0;
      remain_q <= '0;
    end else if (accept_i) begin
      phase_q  <= phase_d;
      idx_q    <= idx_d;
      skip_q   <= skip_d;
      rle_q    <= rle_d;
      bpp4_q   <= bpp4_d;
      top_q    <= top_d;
      width_q  <= width_d;
      height_q <= height_d;
      plen_q   <= plen_d;
      prep_q   <= prep_d;
      sidx_q   <= sidx_d;
      bad_q    <= bad_d;
      remain_q <= remain_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && sample_we) begin
      sample_q[e_sidx] <= b;
    end
  end

endmodule

// ----- hdl/tga_rle_back.sv -----
// Pixel writer: expands commands into results and tracks destination addresses.
module tga_rle_back
  import tga_rle_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cmd_empty_i,
  input  cmd_t cmd_i,
  output logic cmd_pop_o,
  input  logic res_full_i,
  output logic res_push_o,
  output out_t res_o
);

  logic        busy_q, busy_d;
  cmd_op_e     op_q, op_d;
  cmd_t        cmd_q;
  logic [7:0]  left_q, left_d;
  logic [15:0] col_q, col_d;
  logic [23:0] base_q, base_d;
  logic [15:0] width_q, width_d;
  logic        top_q, top_d;
  logic        load, emit, two, final_res;
  logic [16:0] col1, col2;
  logic        wrap1, wrap2;
  logic [15:0] col_s1, col_s2;
  logic [23:0] base_s1, base_s2;
  logic [23:0] addr_a, addr_b;
  out_t        res;

  assign load      = !busy_q && !cmd_empty_i;
  assign cmd_pop_o = load;
  assign emit      = busy_q && !res_full_i;

  // Two raster steps per cycle while the result queue has room: column wraps move the row start by one line.
  always_comb begin
    addr_a  = base_q + {8'd0, col_q};
    col1    = {1'b0, col_q} + 17'd1;
    wrap1   = (col1 >= {1'b0, width_q});
    col_s1  = wrap1 ? 16'd0 : col1[15:0];
    base_s1 = wrap1 ? (top_q ? base_q + {8'd0, width_q} : base_q - {8'd0, width_q})
                    : base_q;
    addr_b  = base_s1 + {8'd0, col_s1};
    col2    = {1'b0, col_s1} + 17'd1;
    wrap2   = (col2 >= {1'b0, width_q});
    col_s2  = wrap2 ? 16'd0 : col2[15:0];
    base_s2 = wrap2 ? (top_q ? base_s1 + {8'd0, width_q} : base_s1 - {8'd0, width_q})
                    : base_s1;
  end

  always_comb begin
    busy_d    = busy_q;
    op_d      = op_q;
    left_d    = left_q;
    col_d     = col_q;
    base_d    = base_q;
    width_d   = width_q;
    top_d     = top_q;
    two       = (left_q >= 8'd2);
    final_res = (left_q <= 8'd2);
    res       = '0;
    res.kind  = KIND_TRUNC;

    case (op_q)
      CMD_PIXELS: begin
        res.kind          = (final_res && cmd_q.trunc) ? KIND_TRUNC : KIND_PIXELS;
        res.pixel_count   = two ? 2'd2 : 2'd1;
        res.address_a     = addr_a;
        res.color_a       = cmd_q.color;
        res.address_b     = two ? addr_b : 24'd0;
        res.color_b       = two ? cmd_q.color : 32'd0;
        res.image_done    = final_res && cmd_q.done;
        res.last_of_burst = final_res;
      end
      CMD_HDR_OK: begin
        res.kind          = KIND_HDR_OK;
        res.image_width   = cmd_q.width[12:0];
        res.image_height  = cmd_q.height;
        res.last_of_burst = !cmd_q.trunc;
      end
      CMD_HDR_BAD: begin
        res.kind          = KIND_HDR_BAD;
        res.last_of_burst = 1'b1;
      end
      default: begin
        res.kind          = KIND_TRUNC;
        res.last_of_burst = 1'b1;
      end
    endcase

    if (load) begin
      busy_d = 1'b1;
      op_d   = cmd_i.op;
      left_d = cmd_i.count;
    end else if (emit) begin
      case (op_q)
        CMD_PIXELS: begin
          left_d = left_q - (two ? 8'd2 : 8'd1);
          col_d  = two ? col_s2 : col_s1;
          base_d = two ? base_s2 : base_s1;
          busy_d = !final_res;
        end
        CMD_HDR_OK: begin
          col_d   = 16'd0;
          base_d  = cmd_q.base;
          width_d = cmd_q.width;
          top_d   = cmd_q.top;
          // A truncated header is followed by its own truncation result.
          if (cmd_q.trunc) begin
            op_d = CMD_TRUNC;
          end else begin
            busy_d = 1'b0;
          end
        end
        default: busy_d = 1'b0;
      endcase
    end
  end

  assign res_push_o = emit;
  assign res_o      = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      op_q    <= CMD_TRUNC;
      left_q  <= '0;
      col_q   <= '0;
      base_q  <= '0;
      width_q <= '0;
      top_q   <= 1'b0;
    end else begin
      busy_q  <= busy_d;
      op_q    <= op_d;
      left_q  <= left_d;
      col_q   <= col_d;
      base_q  <= base_d;
      width_q <= width_d;
      top_q   <= top_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cmd_q <= cmd_i;
    end
  end

endmodule

// ----- hdl/tga_rle_image_decoder_unit.sv -----
// Top level of the streaming TGA (24/32-bit, raw or run-length) image decoder.
//
// Usage: the file enters one byte per transfer on the input port (push, full,
// data_i); first_of_file restarts the decoder and end_of_file marks the final
// byte. Results leave through the output queue (empty, pop, result_o): one
// header verdict per file, then pixel writes of up to two RGBA pixels each,
// with their destination index, and a truncation report if the file ends early.
// A byte parser checks the header, skips the ID field, reads packet headers and
// assembles pixels; it hands at most one command per byte to a two-entry
// command queue.
// A pixel writer turns each command into results and keeps the raster address.
// Throughput: one byte per cycle while the command queue has room; a run of pixels
// occupies the writer while it loads the command and emits up to two pixels per result,
// during which further bytes still enter until the command queue holds two commands.
// When the receiver stalls, the two-entry result queue fills, the writer waits,
// and full rises once the command queue is also full; nothing is dropped.
// Reset clears all queues and returns the parser to the header; bytes that
// arrive before any first_of_file are taken as the start of a file.
module tga_rle_image_decoder_unit
  import tga_rle_pkg::*;
#(
  parameter int MaxWidth  = MaxWidthDefault,
  parameter int MaxHeight = MaxHeightDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push,
  output logic full,
  input  in_t  data_i,
  output logic empty,
  input  logic pop,
  output out_t result_o
);

  logic accept;
  logic cmd_push, cmd_full, cmd_empty, cmd_pop;
  cmd_t cmd_in, cmd_out;
  logic res_push, res_full;
  out_t res_in;

  // A byte is taken only while a command slot is free, whether or not it yields one.
  assign full   = cmd_full;
  assign accept = push && !cmd_full;

  tga_rle_front #(
    .MaxWidth  (MaxWidth),
    .MaxHeight (MaxHeight)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .data_i     (data_i),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in)
  );

  tga_rle_fifo #(
    .Width ($bits(cmd_t)),
    .Depth (2)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_out),
    .empty_o (cmd_empty)
  );

  tga_rle_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  // The result queue doubles as the output register toward the receiver.
  tga_rle_fifo #(
    .Width ($bits(out_t)),
    .Depth (2)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (result_o),
    .empty_o (empty)
  );

endmodule
